/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/ipfe_pkg.sv */
// shared types and constants of the imu packet field extractor
`timescale 1ns / 1ps

package ipfe_pkg;

    localparam int KIND_COUNT  = 3;
    localparam int SCALE_W     = 28;
    localparam int VALUE_W     = 29;
    localparam int RAW_W       = 16;
    localparam int PROD_W      = RAW_W + SCALE_W + 1;
    localparam int FRAC_SHIFT  = 15;
    localparam int DATA_BYTES  = 6;

    localparam logic [7:0] SYNC_BYTE = 8'h55;

    // packet kinds, also the result code on packet_kind
    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    // configuration register indexes
    localparam logic [1:0] CFG_ACCEL_SCALE = 2'd0;
    localparam logic [1:0] CFG_RATE_SCALE  = 2'd1;
    localparam logic [1:0] CFG_ANGLE_SCALE = 2'd2;

    localparam logic [SCALE_W-1:0] ACCEL_SCALE_RST = 28'd10276045;
    localparam logic [SCALE_W-1:0] RATE_SCALE_RST  = 28'd131072000;
    localparam logic [SCALE_W-1:0] ANGLE_SCALE_RST = 28'd11796480;

    // capture progress codes
    localparam logic [2:0] PROG_IDLE = 3'd0;
    localparam logic [2:0] PROG_DONE = 3'd7;

    // header byte that follows the sync byte, per kind
    function automatic logic [7:0] kind_header(input logic [1:0] k);
        logic [7:0] h;
        case (k)
            KIND_ACCEL: h = 8'h51;
            KIND_RATE:  h = 8'h52;
            KIND_ANGLE: h = 8'h53;
            default:    h = 8'h00;
        endcase
        return h;
    endfunction

    // one finished buffer: found flags and the six data bytes of each kind
    typedef struct packed {
        logic [KIND_COUNT-1:0]                  found;
        logic [KIND_COUNT-1:0][8*DATA_BYTES-1:0] data;
    } job_t;

    // one result item
    typedef struct packed {
        kind_t                     kind;
        logic                      found;
        logic signed [VALUE_W-1:0] value_x;
        logic signed [VALUE_W-1:0] value_y;
        logic signed [VALUE_W-1:0] value_z;
        logic                      last;
    } result_t;

endpackage

/* hw/rtl/imu_packet_field_extractor.sv */
// path: a buffer's last byte pushes it into the job queue; its three results then pass the
// product stage and are written to the result queue. throughput: one byte per cycle while
// full is low; the back part gives one result per cycle while the result queue has room,
// so a buffer shorter than three bytes holds input through the job queue
// reset: async active low, clears tracking, queues and restores the scale registers
`timescale 1ns / 1ps

module imu_packet_field_extractor #(
    parameter int JOB_DEPTH = 2,
    parameter int OUT_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [1:0]                    cfg_index,
    input  logic [ipfe_pkg::SCALE_W-1:0]  cfg_data,
    input  logic                          push,
    output logic                          full,
    input  logic [7:0]                    rx_byte,
    input  logic                          buffer_end,
    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    packet_kind,
    output logic                          found,
    output logic signed [ipfe_pkg::VALUE_W-1:0] value_x,
    output logic signed [ipfe_pkg::VALUE_W-1:0] value_y,
    output logic signed [ipfe_pkg::VALUE_W-1:0] value_z,
    output logic                          last_of_run
);

    import ipfe_pkg::*;

    localparam int OUT_CW = $clog2(OUT_DEPTH + 1);

    logic              take;
    logic              job_push;
    job_t              job_in;
    job_t              job_out;
    logic              job_pop;
    logic              job_empty;
    logic              res_push;
    result_t           res_in;
    result_t           res_out;
    logic [OUT_CW-1:0] out_count;

    assign take = push && !full;

    // byte tracking
    ipfe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .rx_byte    (rx_byte),
        .buffer_end (buffer_end),
        .job_push   (job_push),
        .job        (job_in)
    );

    // finished buffers waiting for the scaler
    ipfe_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .full    (full),
        .empty   (job_empty),
        .count   ()
    );

    // scaling
    ipfe_back #(
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_count (out_count),
        .res_push  (res_push),
        .res       (res_in)
    );

    // result queue toward the consumer
    ipfe_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .rd_en   (pop),
        .rd_data (res_out),
        .full    (),
        .empty   (empty),
        .count   (out_count)
    );

    assign packet_kind = res_out.kind;
    assign found       = res_out.found;
    assign value_x     = res_out.value_x;
    assign value_y     = res_out.value_y;
    assign value_z     = res_out.value_z;
    assign last_of_run = res_out.last;

endmodule

/* hw/rtl/ipfe_fifo.sv */
// small register queue with count, used between the pipeline parts and toward the consumer
`timescale 1ns / 1ps

module ipfe_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         wr_en,
    input  logic [WIDTH-1:0]             wr_data,
    input  logic                         rd_en,
    output logic [WIDTH-1:0]             rd_data,
    output logic                         full,
    output logic                         empty,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* hw/rtl/ipfe_front.sv */
// byte tracker: finds header pairs per kind and captures the data bytes
`timescale 1ns / 1ps

module ipfe_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          take,
    input  logic [7:0]    rx_byte,
    input  logic          buffer_end,
    output logic          job_push,
    output ipfe_pkg::job_t job
);

    import ipfe_pkg::*;

    logic [7:0] prev_reg;
    logic [2:0] prog_reg  [KIND_COUNT];
    logic [2:0] prog_next [KIND_COUNT];
    logic [DATA_BYTES-1:0][7:0] bytes_reg  [KIND_COUNT];
    logic [DATA_BYTES-1:0][7:0] bytes_next [KIND_COUNT];

    // per kind capture step for the byte being taken
    always_comb
    begin
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            prog_next[k]  = prog_reg[k];
            bytes_next[k] = bytes_reg[k];
            if (take)
            begin
                if (prog_reg[k] == PROG_IDLE)
                begin
                    if (prev_reg == SYNC_BYTE && rx_byte == kind_header(2'(k)))
                    begin
                        prog_next[k] = 3'd1;
                    end
                end
                else if (prog_reg[k] != PROG_DONE)
                begin
                    bytes_next[k][prog_reg[k] - 3'd1] = rx_byte;
                    prog_next[k] = prog_reg[k] + 3'd1;
                end
            end
        end
    end

    // finished buffer goes out as one item for the back part
    always_comb
    begin
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            job.found[k] = (prog_next[k] == PROG_DONE);
            job.data[k]  = job.found[k] ? bytes_next[k] : '0;
        end
    end

    assign job_push = take && buffer_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg <= '0;
            for (int k = 0; k < KIND_COUNT; k++)
            begin
                prog_reg[k] <= PROG_IDLE;
            end
        end
        else if (take)
        begin
            if (buffer_end)
            begin
                prev_reg <= '0;
                for (int k = 0; k < KIND_COUNT; k++)
                begin
                    prog_reg[k] <= PROG_IDLE;
                end
            end
            else
            begin
                prev_reg <= rx_byte;
                for (int k = 0; k < KIND_COUNT; k++)
                begin
                    prog_reg[k] <= prog_next[k];
                end
            end
        end
    end

    // captured bytes, only read once a kind is complete
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < KIND_COUNT; k++)
        begin
            bytes_reg[k] <= bytes_next[k];
        end
    end

endmodule

/* hw/rtl/ipfe_back.sv */
// scaler: 3 lane multipliers, product stage; 1 result/cycle if not stalled
`timescale 1ns / 1ps

module ipfe_back #(
    parameter int OUT_DEPTH = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [1:0]                        cfg_index,
    input  logic [ipfe_pkg::SCALE_W-1:0]      cfg_data,
    input  logic                              job_empty,
    input  ipfe_pkg::job_t                    job,
    output logic                              job_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]    out_count,
    output logic                              res_push,
    output ipfe_pkg::result_t                 res
);

    import ipfe_pkg::*;

    localparam int CW = $clog2(OUT_DEPTH + 1);

    logic [SCALE_W-1:0]       accel_scale_reg;
    logic [SCALE_W-1:0]       rate_scale_reg;
    logic [SCALE_W-1:0]       angle_scale_reg;
    kind_t                    kind_reg, kind_next;
    logic                     issue;
    logic [SCALE_W-1:0]       scale_sel;
    logic [8*DATA_BYTES-1:0]  data_sel;
    logic signed [PROD_W-1:0] scale_ext;
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [PROD_W-1:0] prod_reg  [3];
    logic                     stage_valid_reg;
    kind_t                    stage_kind_reg;
    logic                     stage_found_reg;

    // scale registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg <= ACCEL_SCALE_RST;
            rate_scale_reg  <= RATE_SCALE_RST;
            angle_scale_reg <= ANGLE_SCALE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ACCEL_SCALE: accel_scale_reg <= cfg_data;
                CFG_RATE_SCALE:  rate_scale_reg  <= cfg_data;
                CFG_ANGLE_SCALE: angle_scale_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // issue when a job waits and the result queue has a free slot
    assign issue   = !job_empty &&
                     (({1'b0, out_count} + (CW+1)'(stage_valid_reg)) < (CW+1)'(OUT_DEPTH));
    assign job_pop = issue && (kind_reg == KIND_ANGLE);

    // kind step and lane operand select
    always_comb
    begin
        case (kind_reg)
            KIND_ACCEL:
            begin
                kind_next = KIND_RATE;
                scale_sel = accel_scale_reg;
                data_sel  = job.data[0];
            end
            KIND_RATE:
            begin
                kind_next = KIND_ANGLE;
                scale_sel = rate_scale_reg;
                data_sel  = job.data[1];
            end
            KIND_ANGLE:
            begin
                kind_next = KIND_ACCEL;
                scale_sel = angle_scale_reg;
                data_sel  = job.data[2];
            end
            default:
            begin
                kind_next = KIND_ACCEL;
                scale_sel = '0;
                data_sel  = '0;
            end
        endcase
    end

    // raw axis times scale, one multiplier per axis
    always_comb
    begin
        scale_ext = PROD_W'($signed({1'b0, scale_sel}));
        for (int a = 0; a < 3; a++)
        begin
            prod_next[a] = PROD_W'($signed(data_sel[RAW_W*a +: RAW_W])) * scale_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg        <= KIND_ACCEL;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= issue;
            if (issue)
            begin
                kind_reg <= kind_next;
            end
        end
    end

    // product stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            stage_kind_reg  <= kind_reg;
            stage_found_reg <= job.found[kind_reg];
            for (int a = 0; a < 3; a++)
            begin
                prod_reg[a] <= prod_next[a];
            end
        end
    end

    // floor divide by 32768 is an arithmetic shift, kept to the value width
    assign res_push      = stage_valid_reg;
    assign res.kind      = stage_kind_reg;
    assign res.found     = stage_found_reg;
    assign res.value_x   = prod_reg[0][FRAC_SHIFT +: VALUE_W];
    assign res.value_y   = prod_reg[1][FRAC_SHIFT +: VALUE_W];
    assign res.value_z   = prod_reg[2][FRAC_SHIFT +: VALUE_W];
    assign res.last      = (stage_kind_reg == KIND_ANGLE);

endmodule

/* hw/rtl/ipfe_checker.sv */
// port level checks of the imu packet field extractor and their binding
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipfe_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [1:0]                    packet_kind,
    input logic signed [ipfe_pkg::VALUE_W-1:0] value_x,
    input logic                          last_of_run
);

    import ipfe_pkg::*;

    // nothing to deliver right after reset
    `ASSERT_ALWAYS(a_empty_after_reset, clk, !rst_n |=> empty, "results present after reset")

    // a waiting item holds still
    `ASSERT_CLK(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(packet_kind) && $stable(value_x)), "waiting item changed")

    // kinds come out in order within a buffer
    `ASSERT_CLK(a_accel_then_rate, clk, rst_n, (pop && !empty && packet_kind == KIND_ACCEL) |=> (empty || packet_kind == KIND_RATE), "rate result does not follow acceleration")
    `ASSERT_CLK(a_rate_then_angle, clk, rst_n, (pop && !empty && packet_kind == KIND_RATE) |=> (empty || packet_kind == KIND_ANGLE), "angle result does not follow rate")

    // a new buffer starts with acceleration
    `ASSERT_CLK(a_run_restart, clk, rst_n, (pop && !empty && last_of_run) |=> (empty || packet_kind == KIND_ACCEL), "buffer results do not restart at acceleration")

endmodule

bind imu_packet_field_extractor ipfe_checker u_ipfe_checker (.*);
